FILE: src/shs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shs_pkg: shared types, constants and functions of the SHA-256 stream hasher
// Payload structs of both channels, round constants, the initial hash and
// the sigma functions of the round and message schedule.
// ---------------------------------------------------------------------------
package shs_pkg;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] message_byte;
    logic       has_byte;
    logic       end_of_message;
  } shs_in_t;

  // Output transaction payload
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } shs_out_t;

  // Working variables a..h, element 0 is a
  typedef logic [7:0][31:0] shs_vars_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned HashWords  = 8;
  localparam int unsigned WinWords   = 16;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [7:0]  ZERO_BYTE  = 8'h00;
  localparam logic [5:0]  LEN_START  = 6'd56;
  localparam logic [5:0]  FILL_LAST  = 6'd63;
  localparam logic [5:0]  ROUND_LAST = 6'd63;
  localparam logic [2:0]  WORD_LAST  = 3'd7;
  localparam logic [63:0] BLOCK_BITS = 64'd512;

  localparam logic [31:0] INIT_HASH [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

FILE: src/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha256_stream_hasher_top: SHA-256 over a byte stream
// Collects message bytes into 512-bit blocks, compresses each block with an
// iterative round unit, pads at end of message and streams out the digest.
// ---------------------------------------------------------------------------
// Each input transaction carries at most one byte and may end the message.
// Bytes are taken one per cycle while the input is ready; the 64th byte of
// a block starts the compression, which runs one round per cycle on a
// single shared round unit and then folds into the chaining hash. At end
// of message, padding and the length field are fed one byte per cycle
// through the same byte path, with one or two compressions, then the eight
// digest words leave as eight output transactions, word 0 first. The input
// is not ready from the end of a block or message until that work and the
// digest are done. The 64-byte block is held in the 16-word schedule shift
// line itself.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_top
  import shs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  shs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output shs_out_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD_START,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_MSG,
    MODE_PAD,
    MODE_FINAL
  } mode_t;

  state_t      state;
  mode_t       mode;
  logic [31:0] hash [HashWords];
  logic [31:0] window [WinWords];
  shs_vars_t   vars;
  shs_vars_t   vars_next;
  logic [31:0] w_new;
  logic [23:0] acc;
  logic [5:0]  fill;
  logic [5:0]  round;
  logic [63:0] bit_count;
  logic [63:0] msg_len;
  logic        eom_pending;
  logic [2:0]  word_idx;
  logic        push_en;
  logic [7:0]  push_byte;
  logic        fill_full;

  // Shared round and schedule unit
  shs_round u_round (
    .vars      (vars),
    .w_cur     (window[0]),
    .w_m15     (window[1]),
    .w_m7      (window[9]),
    .w_m2      (window[14]),
    .k         (ROUND_K[round]),
    .vars_next (vars_next),
    .w_new     (w_new)
  );

  assign fill_full = (fill == FILL_LAST);
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // Drive the digest word from the chaining hash
  always_comb begin
    out_data.digest_word = hash[word_idx];
    out_data.word_index  = word_idx;
    out_data.last_word   = (word_idx == WORD_LAST);
  end

  // Select the byte to append: message, pad mark, zero or length
  always_comb begin
    push_en   = 1'b0;
    push_byte = ZERO_BYTE;
    case (state)
      ST_IDLE: begin
        push_en   = in_valid && in_data.has_byte;
        push_byte = in_data.message_byte;
      end
      ST_PAD_START: begin
        push_en   = 1'b1;
        push_byte = PAD_BYTE;
      end
      ST_PAD: begin
        push_en = (fill != LEN_START);
      end
      ST_LEN: begin
        push_en   = 1'b1;
        push_byte = msg_len[{~fill[2:0], 3'b000} +: 8];
      end
      default: begin
        push_en = 1'b0;
      end
    endcase
  end

  // Sequencer, byte path, schedule line and hash state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mode        <= MODE_MSG;
      fill        <= '0;
      round       <= '0;
      bit_count   <= '0;
      eom_pending <= 1'b0;
      word_idx    <= '0;
      for (int i = 0; i < HashWords; i++) begin
        hash[i] <= INIT_HASH[i];
      end
    end else begin
      // Append one byte; every fourth byte completes a word
      if (push_en) begin
        acc  <= {acc[15:0], push_byte};
        fill <= fill + 6'd1;
        if (fill[1:0] == 2'b11) begin
          for (int i = 0; i < WinWords - 1; i++) begin
            window[i] <= window[i + 1];
          end
          window[WinWords - 1] <= {acc, push_byte};
        end
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.has_byte && fill_full) begin
              state       <= ST_ROUND;
              mode        <= MODE_MSG;
              round       <= '0;
              eom_pending <= in_data.end_of_message;
              for (int i = 0; i < HashWords; i++) begin
                vars[i] <= hash[i];
              end
            end else if (in_data.end_of_message) begin
              state <= ST_PAD_START;
            end
          end
        end
        ST_PAD_START: begin
          msg_len <= bit_count + {55'b0, fill, 3'b000};
          if (fill_full) begin
            state <= ST_ROUND;
            mode  <= MODE_PAD;
            round <= '0;
            for (int i = 0; i < HashWords; i++) begin
              vars[i] <= hash[i];
            end
          end else begin
            state <= ST_PAD;
          end
        end
        ST_PAD: begin
          if (fill == LEN_START) begin
            state <= ST_LEN;
          end else if (fill_full) begin
            state <= ST_ROUND;
            mode  <= MODE_PAD;
            round <= '0;
            for (int i = 0; i < HashWords; i++) begin
              vars[i] <= hash[i];
            end
          end
        end
        ST_LEN: begin
          if (fill_full) begin
            state <= ST_ROUND;
            mode  <= MODE_FINAL;
            round <= '0;
            for (int i = 0; i < HashWords; i++) begin
              vars[i] <= hash[i];
            end
          end
        end
        ST_ROUND: begin
          // One round; advance the schedule line by one word
          vars  <= vars_next;
          round <= round + 6'd1;
          for (int i = 0; i < WinWords - 1; i++) begin
            window[i] <= window[i + 1];
          end
          window[WinWords - 1] <= w_new;
          if (round == ROUND_LAST) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < HashWords; i++) begin
            hash[i] <= hash[i] + vars[i];
          end
          case (mode)
            MODE_MSG: begin
              bit_count   <= bit_count + BLOCK_BITS;
              eom_pending <= 1'b0;
              state       <= eom_pending ? ST_PAD_START : ST_IDLE;
            end
            MODE_PAD: begin
              state <= ST_PAD;
            end
            MODE_FINAL: begin
              state    <= ST_OUT;
              word_idx <= '0;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_OUT: begin
          // Hand out one digest word per transaction, then reinitialize
          if (out_ready) begin
            if (word_idx == WORD_LAST) begin
              state     <= ST_IDLE;
              bit_count <= '0;
              for (int i = 0; i < HashWords; i++) begin
                hash[i] <= INIT_HASH[i];
              end
            end else begin
              word_idx <= word_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/shs_round.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shs_round: one SHA-256 round and one message schedule step
// Shared combinational unit used once per cycle by the sequencer: computes
// the next working variables from the current word and the next schedule
// word from the window taps.
// ---------------------------------------------------------------------------
module shs_round
  import shs_pkg::*;
(
  input  shs_vars_t   vars,
  input  logic [31:0] w_cur,
  input  logic [31:0] w_m15,
  input  logic [31:0] w_m7,
  input  logic [31:0] w_m2,
  input  logic [31:0] k,
  output shs_vars_t   vars_next,
  output logic [31:0] w_new
);

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  // Round temporaries
  assign ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1  = vars[7] + big_sigma1(vars[4]) + ch + k + w_cur;
  assign t2  = big_sigma0(vars[0]) + maj;

  // Rotate the working variables
  always_comb begin
    vars_next[0] = t1 + t2;
    vars_next[1] = vars[0];
    vars_next[2] = vars[1];
    vars_next[3] = vars[2];
    vars_next[4] = vars[3] + t1;
    vars_next[5] = vars[4];
    vars_next[6] = vars[5];
    vars_next[7] = vars[6];
  end

  // Next schedule word, sixteen ahead of the current one
  assign w_new = small_sigma1(w_m2) + w_m7 + small_sigma0(w_m15) + w_cur;

endmodule
